// File: hdl/dtkc_pkg.sv
// shared types, codes and defaults for the digit trie key counter
`timescale 1ns / 1ps
`default_nettype none
package dtkc_pkg;

  // default sizing
  localparam int MAX_NODES_DEF      = 4096;
  localparam int RADIX_DEF          = 10;
  localparam int MAX_KEY_DIGITS_DEF = 16;
  localparam int COUNT_BITS_DEF     = 32;

  // fixed field widths
  localparam int KEY_LEN_W = 5;
  localparam int POS_W     = 5;
  localparam int DIGIT_W   = 4;
  localparam int OUT_CNT_W = 32;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // register map
  localparam logic [APB_AW-1:0]    REG_KEY_LENGTH = 3'd0;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET  = 5'd14;

  // operation codes
  localparam logic OP_DIGIT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result status codes
  localparam logic ST_COUNTED   = 1'b0;
  localparam logic ST_POOL_FULL = 1'b1;

  // walker states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ALLOC,
    S_COUNT,
    S_PUT
  } dtkc_state_t;

  // row memory access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } dtkc_ram_ctl_t;

endpackage
`default_nettype wire

// File: hdl/dtkc_row_ram.sv
// node row memory: one row per trie node, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module dtkc_row_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 152
) (
  input  wire                     clk,
  input  dtkc_pkg::dtkc_ram_ctl_t ctl,
  input  wire  [AW-1:0]           raddr,
  input  wire  [AW-1:0]           waddr,
  input  wire  [DW-1:0]           wdata,
  output logic [DW-1:0]           rdata
);
  import dtkc_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/dtkc_cfg_regs.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps
`default_nettype none
module dtkc_cfg_regs (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [dtkc_pkg::APB_AW-1:0]      paddr,
  input  wire  [dtkc_pkg::APB_DW-1:0]      pwdata,
  output logic [dtkc_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  output logic [dtkc_pkg::KEY_LEN_W-1:0]   key_length
);
  import dtkc_pkg::*;

  logic [KEY_LEN_W-1:0] key_length_r;
  logic [KEY_LEN_W-1:0] key_length_nxt;
  logic                 wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == REG_KEY_LENGTH);

  // register write
  always_comb begin
    key_length_nxt = key_length_r;
    if (wr_hit) begin
      key_length_nxt = pwdata[KEY_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_RESET;
    end else begin
      key_length_r <= key_length_nxt;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_KEY_LENGTH) begin
      prdata = {{(APB_DW-KEY_LEN_W){1'b0}}, key_length_r};
    end
  end

  assign key_length = key_length_r;

endmodule
`default_nettype wire

// File: hdl/dtkc_walk_ctrl.sv
// trie walker: reads a node row, follows or allocates a child, updates the leaf count
`timescale 1ns / 1ps
`default_nettype none
module dtkc_walk_ctrl #(
  parameter int MAX_NODES      = 4096,
  parameter int RADIX          = 10,
  parameter int MAX_KEY_DIGITS = 16,
  parameter int COUNT_BITS     = 32,
  parameter int NODE_W         = 12,
  parameter int ROW_W          = 152
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [dtkc_pkg::KEY_LEN_W-1:0]    key_length,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_operation,
  input  wire  [dtkc_pkg::DIGIT_W-1:0]      in_digit,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [dtkc_pkg::OUT_CNT_W-1:0]    out_previous_count,
  output logic                              out_status,
  output dtkc_pkg::dtkc_ram_ctl_t           ram_ctl,
  output logic [NODE_W-1:0]                 ram_raddr,
  output logic [NODE_W-1:0]                 ram_waddr,
  output logic [ROW_W-1:0]                  ram_wdata,
  input  wire  [ROW_W-1:0]                  ram_rdata
);
  import dtkc_pkg::*;

  localparam int FREE_W = $clog2(MAX_NODES + 1);
  localparam int SLOT_W = $clog2(RADIX);
  localparam logic [FREE_W-1:0]    FREE_LIMIT = FREE_W'(MAX_NODES);
  localparam logic [DIGIT_W:0]     RADIX_L    = (DIGIT_W+1)'(RADIX);
  localparam logic [SLOT_W-1:0]    DIGIT_TOP  = SLOT_W'(RADIX - 1);
  localparam logic [KEY_LEN_W-1:0] LEN_TOP    = KEY_LEN_W'(MAX_KEY_DIGITS);

  // control state
  dtkc_state_t          state_r, state_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 failed_r, failed_nxt;
  logic [FREE_W-1:0]    free_r, free_nxt;
  logic                 root_valid_r, root_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload state
  logic [SLOT_W-1:0]     digit_r, digit_nxt;
  logic                  last_r, last_nxt;
  logic [COUNT_BITS-1:0] res_cnt_r, res_cnt_nxt;
  logic                  res_st_r, res_st_nxt;
  logic [OUT_CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                  out_st_r, out_st_nxt;

  // row views
  logic [COUNT_BITS-1:0]             raw_cnt;
  logic [RADIX-1:0][NODE_W-1:0]      raw_kids;
  logic [RADIX-1:0][NODE_W-1:0]      kids_m;
  logic [RADIX-1:0][NODE_W-1:0]      kids_upd;
  logic [NODE_W-1:0]                 kid;
  logic [COUNT_BITS-1:0]             cnt_inc;
  logic [OUT_CNT_W+COUNT_BITS-1:0]   res_ext;

  // incoming item decode
  logic [SLOT_W-1:0]     dig_sat;
  logic [KEY_LEN_W-1:0]  eff_len;
  logic                  last_now;
  logic [POS_W-1:0]      pos_inc;

  assign {raw_cnt, raw_kids} = ram_rdata;

  // root row counts as empty until first written after reset or clear
  assign kids_m = ((cur_r == '0) && !root_valid_r) ? '0 : raw_kids;
  assign kid    = kids_m[digit_r];

  always_comb begin
    kids_upd          = kids_m;
    kids_upd[digit_r] = free_r[NODE_W-1:0];
  end

  // saturating count increment
  assign cnt_inc = (raw_cnt == '1) ? raw_cnt : raw_cnt + 1'b1;
  assign res_ext = {{OUT_CNT_W{1'b0}}, res_cnt_r};

  // digit clamp and key end detect
  always_comb begin
    dig_sat = in_digit[SLOT_W-1:0];
    if ({1'b0, in_digit} >= RADIX_L) begin
      dig_sat = DIGIT_TOP;
    end
    eff_len = key_length;
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > LEN_TOP) begin
      eff_len = LEN_TOP;
    end
  end

  assign pos_inc  = pos_r + 1'b1;
  assign last_now = ({1'b0, pos_r} + (POS_W+1)'(1)) >= {1'b0, eff_len};

  // next state and memory strobes
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    failed_nxt     = failed_r;
    free_nxt       = free_r;
    root_valid_nxt = root_valid_r;
    digit_nxt      = digit_r;
    last_nxt       = last_r;
    res_cnt_nxt    = res_cnt_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_cnt_nxt    = out_cnt_r;
    out_st_nxt     = out_st_r;
    ram_ctl        = '0;
    ram_raddr      = cur_r;
    ram_waddr      = cur_r;
    ram_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_CLEAR) begin
            // drop every node, restart the pool
            free_nxt       = FREE_W'(1);
            cur_nxt        = '0;
            pos_nxt        = '0;
            failed_nxt     = 1'b0;
            root_valid_nxt = 1'b0;
          end else begin
            digit_nxt = dig_sat;
            last_nxt  = last_now;
            if (failed_r) begin
              // key already lost, just consume digits
              if (last_now) begin
                res_cnt_nxt = '0;
                res_st_nxt  = ST_POOL_FULL;
                cur_nxt     = '0;
                pos_nxt     = '0;
                failed_nxt  = 1'b0;
                state_nxt   = S_PUT;
              end else begin
                pos_nxt = pos_inc;
              end
            end else begin
              ram_ctl.rd_en = 1'b1;
              state_nxt     = S_LOOK;
            end
          end
        end
      end

      S_LOOK: begin
        if (kid != '0) begin
          // child exists
          cur_nxt = kid;
          if (last_r) begin
            ram_ctl.rd_en = 1'b1;
            ram_raddr     = kid;
            state_nxt     = S_COUNT;
          end else begin
            pos_nxt   = pos_inc;
            state_nxt = S_IDLE;
          end
        end else if (free_r < FREE_LIMIT) begin
          // link a fresh node into the parent row
          ram_ctl.wr_en = 1'b1;
          ram_wdata     = {raw_cnt, kids_upd};
          if (cur_r == '0) begin
            root_valid_nxt = 1'b1;
          end
          cur_nxt   = free_r[NODE_W-1:0];
          free_nxt  = free_r + 1'b1;
          state_nxt = S_ALLOC;
        end else begin
          // pool exhausted
          if (last_r) begin
            res_cnt_nxt = '0;
            res_st_nxt  = ST_POOL_FULL;
            cur_nxt     = '0;
            pos_nxt     = '0;
            failed_nxt  = 1'b0;
            state_nxt   = S_PUT;
          end else begin
            failed_nxt = 1'b1;
            pos_nxt    = pos_inc;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_ALLOC: begin
        // fresh row: no children, count zero, or one if it ends the key
        ram_ctl.wr_en = 1'b1;
        ram_wdata     = {{{(COUNT_BITS-1){1'b0}}, last_r}, {(RADIX*NODE_W){1'b0}}};
        if (last_r) begin
          res_cnt_nxt = '0;
          res_st_nxt  = ST_COUNTED;
          cur_nxt     = '0;
          pos_nxt     = '0;
          failed_nxt  = 1'b0;
          state_nxt   = S_PUT;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = S_IDLE;
        end
      end

      S_COUNT: begin
        // leaf row read back, bump its count
        ram_ctl.wr_en = 1'b1;
        ram_wdata     = {cnt_inc, raw_kids};
        res_cnt_nxt   = raw_cnt;
        res_st_nxt    = ST_COUNTED;
        cur_nxt       = '0;
        pos_nxt       = '0;
        failed_nxt    = 1'b0;
        state_nxt     = S_PUT;
      end

      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = res_ext[OUT_CNT_W-1:0];
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      pos_r        <= '0;
      failed_r     <= 1'b0;
      free_r       <= FREE_W'(1);
      root_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      pos_r        <= pos_nxt;
      failed_r     <= failed_nxt;
      free_r       <= free_nxt;
      root_valid_r <= root_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    digit_r   <= digit_nxt;
    last_r    <= last_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_st_r  <= res_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_previous_count = out_cnt_r;
  assign out_status         = out_st_r;

endmodule
`default_nettype wire

// File: hdl/digit_trie_key_counter_core.sv
// top level of the digit trie key counter
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_ready  in_operation, in_digit
//  out_     output     out_valid/out_ready out_previous_count, out_status
//  config   input      psel/penable       paddr, pwdata, prdata (key_length at 0x0)
//
// a digit that finds its child does a row read; one that allocates a node adds a
// link write and a row write. a key's last digit does row read, leaf read, count
// write, output load on an existing leaf, or row read, link write, row write,
// output load on a fresh one. a clear or a non-final digit of a failed key is taken
// in idle; its final digit adds an output load, and a last digit on a full pool
// does a row read and output load. the row memory does one read, one write per cycle.
// rst_n is synchronous; the trie is empty right after reset, no clearing pass.
// a stalled result waits in the output register while later digits proceed;
// only the next key's last digit waits for it.
`timescale 1ns / 1ps
`default_nettype none
module digit_trie_key_counter_core #(
  parameter int MAX_NODES      = dtkc_pkg::MAX_NODES_DEF,
  parameter int RADIX          = dtkc_pkg::RADIX_DEF,
  parameter int MAX_KEY_DIGITS = dtkc_pkg::MAX_KEY_DIGITS_DEF,
  parameter int COUNT_BITS     = dtkc_pkg::COUNT_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_operation,
  input  wire  [dtkc_pkg::DIGIT_W-1:0]    in_digit,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [dtkc_pkg::OUT_CNT_W-1:0]  out_previous_count,
  output logic                            out_status,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [dtkc_pkg::APB_AW-1:0]     paddr,
  input  wire  [dtkc_pkg::APB_DW-1:0]     pwdata,
  output logic [dtkc_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import dtkc_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ROW_W  = COUNT_BITS + RADIX * NODE_W;

  logic [KEY_LEN_W-1:0] key_length;
  dtkc_ram_ctl_t        ram_ctl;
  logic [NODE_W-1:0]    ram_raddr;
  logic [NODE_W-1:0]    ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;

  // configuration registers
  dtkc_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_length (key_length)
  );

  // node rows: child links and count
  dtkc_row_ram #(
    .DEPTH (MAX_NODES),
    .AW    (NODE_W),
    .DW    (ROW_W)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .raddr (ram_raddr),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // walker
  dtkc_walk_ctrl #(
    .MAX_NODES      (MAX_NODES),
    .RADIX          (RADIX),
    .MAX_KEY_DIGITS (MAX_KEY_DIGITS),
    .COUNT_BITS     (COUNT_BITS),
    .NODE_W         (NODE_W),
    .ROW_W          (ROW_W)
  ) u_walk (
    .clk                (clk),
    .rst_n              (rst_n),
    .key_length         (key_length),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_digit           (in_digit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_previous_count (out_previous_count),
    .out_status         (out_status),
    .ram_ctl            (ram_ctl),
    .ram_raddr          (ram_raddr),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_rdata          (ram_rdata)
  );

endmodule
`default_nettype wire
